@@ design/urhr_pkg.sv @@
// Shared types and constants for the undo/redo history ring.
package urhr_pkg;

    localparam int SLOTS_DEFAULT      = 16;
    localparam int SNAP_WIDTH_DEFAULT = 64;
    localparam int SNAP_FIELD_W       = 64;
    localparam int DEPTH_FIELD_W      = 4;

    typedef enum logic [1:0] {
        CMD_RESET    = 2'd0,
        CMD_PRESERVE = 2'd1,
        CMD_UNDO     = 2'd2,
        CMD_REDO     = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                    command;
        logic [SNAP_FIELD_W-1:0] snapshot;
    } request_t;

    typedef struct packed {
        logic                     ok;
        logic [SNAP_FIELD_W-1:0]  restored;
        logic [DEPTH_FIELD_W-1:0] undo_left;
        logic [DEPTH_FIELD_W-1:0] redo_left;
    } result_t;

endpackage

@@ design/undo_redo_history_ring.sv @@
// Undo/redo history ring: a ring of snapshot words in one synchronous memory.
//
// A command is transferred at a clock edge where start is high and busy is low;
// busy never rises, so a command may follow in every cycle. Its result appears
// on result, marked by done, in the cycle right after the transfer, one cycle
// set by the registered read port of the history memory, and must be taken
// then: the receiver cannot stall the block. The slot pointer and both depth
// counts update at the transfer edge, so the next command sees them at once; a
// slot written by one command and read by the next is seen correctly because
// the write lands at the edge before the read. Reads of slots never written
// (undo after a preserve without a prior reset command) return unspecified data.
module undo_redo_history_ring
    import urhr_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEFAULT,
    parameter int SNAP_WIDTH = SNAP_WIDTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = (PTR_W > DEPTH_FIELD_W) ? PTR_W : DEPTH_FIELD_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);

    logic [SNAP_WIDTH-1:0] history_mem [SLOTS];

    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [PTR_W-1:0] undo_reg, undo_next;
    logic [PTR_W-1:0] redo_reg, redo_next;
    logic             done_reg, done_next;
    logic             ok_reg, ok_next;
    logic             step_reg, step_next;
    logic [SNAP_WIDTH-1:0] rd_data_reg;

    logic                  accept;
    logic [PTR_W-1:0]      ptr_inc, ptr_dec;
    logic                  wr_en, rd_en;
    logic [PTR_W-1:0]      wr_addr, rd_addr;
    logic [SNAP_WIDTH-1:0] wr_data;
    logic [CNT_W-1:0]      undo_wide, redo_wide;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign ptr_inc = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
    assign ptr_dec = (ptr_reg == '0) ? LAST_SLOT : ptr_reg - 1'b1;
    assign wr_data = request.snapshot[SNAP_WIDTH-1:0];

    always_comb
    begin
        ptr_next  = ptr_reg;
        undo_next = undo_reg;
        redo_next = redo_reg;
        done_next = accept;
        ok_next   = ok_reg;
        step_next = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = ptr_inc;
        rd_en     = 1'b0;
        rd_addr   = ptr_inc;
        if (accept)
        begin
            ok_next = 1'b1;
            case (request.command)
                CMD_RESET:
                begin
                    ptr_next  = '0;
                    undo_next = '0;
                    redo_next = '0;
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                end
                CMD_PRESERVE:
                begin
                    ptr_next  = ptr_inc;
                    redo_next = '0;
                    wr_en     = 1'b1;
                    wr_addr   = ptr_inc;
                    if (undo_reg != LAST_SLOT)
                    begin
                        undo_next = undo_reg + 1'b1;
                    end
                end
                CMD_UNDO:
                begin
                    if (undo_reg == '0)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next  = ptr_dec;
                        undo_next = undo_reg - 1'b1;
                        redo_next = redo_reg + 1'b1;
                        step_next = 1'b1;
                        rd_en     = 1'b1;
                        rd_addr   = ptr_dec;
                    end
                end
                CMD_REDO:
                begin
                    if (redo_reg == '0)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next  = ptr_inc;
                        redo_next = redo_reg - 1'b1;
                        undo_next = undo_reg + 1'b1;
                        step_next = 1'b1;
                        rd_en     = 1'b1;
                        rd_addr   = ptr_inc;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            undo_reg <= '0;
            redo_reg <= '0;
            done_reg <= 1'b0;
            ok_reg   <= 1'b0;
            step_reg <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            undo_reg <= undo_next;
            redo_reg <= redo_next;
            done_reg <= done_next;
            ok_reg   <= ok_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            history_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= history_mem[rd_addr];
        end
    end

    // The depth counts already reflect the command once done is high.
    assign undo_wide = CNT_W'(undo_reg);
    assign redo_wide = CNT_W'(redo_reg);

    assign done             = done_reg;
    assign result.ok        = ok_reg;
    assign result.restored  = step_reg ? SNAP_FIELD_W'(rd_data_reg) : '0;
    assign result.undo_left = undo_wide[DEPTH_FIELD_W-1:0];
    assign result.redo_left = redo_wide[DEPTH_FIELD_W-1:0];

endmodule
